[hdl/scsc_pkg.sv]
`timescale 1ns / 1ps
package scsc_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = 64;
    localparam int DEPTH_W     = 9;
    localparam int WIN_W       = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(8);

    typedef enum logic
    {
        CMD_CALL   = 1'b0,
        CMD_RETURN = 1'b1
    } cmd_t;

    typedef enum logic [2:0]
    {
        V_PUSHED       = 3'd0,
        V_GOOD         = 3'd1,
        V_GOOD_BAD_SP  = 3'd2,
        V_BACK_LONGJMP = 3'd3,
        V_OVERWRITE    = 3'd4,
        V_FWD_LONGJMP  = 3'd5,
        V_UNDERFLOW    = 3'd6,
        V_FULL         = 3'd7
    } verdict_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_CHECK,
        ST_UNW_RD,
        ST_UNW_CK,
        ST_EMIT
    } exec_state_t;

    typedef struct packed
    {
        cmd_t               command;
        logic [ADDR_W-1:0]  code_address;
        logic [ADDR_W-1:0]  stack_pointer;
    } in_item_t;

    typedef struct packed
    {
        verdict_t           verdict;
        logic [DEPTH_W-1:0] depth_after;
        logic [ADDR_W-1:0]  shadow_address;
    } out_item_t;

    typedef struct packed
    {
        logic [ADDR_W-1:0]  link_addr;
        logic [ADDR_W-1:0]  sp;
    } frame_t;

    typedef struct packed
    {
        logic               avail;
        in_item_t           item;
    } front_t;

    function automatic logic sp_near(
        input logic [ADDR_W-1:0] a,
        input logic [ADDR_W-1:0] b,
        input logic [WIN_W-1:0]  win
    );
        logic [ADDR_W-1:0] diff;
        diff = (a >= b) ? (a - b) : (b - a);
        return diff <= ADDR_W'(win);
    endfunction

endpackage

[hdl/scsc_in_q.sv]
`timescale 1ns / 1ps
module scsc_in_q
    import scsc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_item_t item,
    output logic     full,
    input  logic     take,
    output front_t   front
);

    in_item_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              wr_en;
    logic              rd_en;

    assign full        = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign wr_en       = push && !full;
    assign rd_en       = take && (count_reg != '0);
    assign front.avail = (count_reg != '0);
    assign front.item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= QPTR_W'((32'(wr_ptr_reg) + 1) % QUEUE_DEPTH);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= QPTR_W'((32'(rd_ptr_reg) + 1) % QUEUE_DEPTH);
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_in_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("input queue count out of range");
    a_in_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("input queue pointers disagree while empty");
    a_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !rd_en) |=> (count_reg == $past(count_reg) + QCNT_W'(1)))
        else $error("input queue lost a transaction");
`endif

endmodule

[hdl/scsc_out_q.sv]
`timescale 1ns / 1ps
module scsc_out_q
    import scsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      res_push,
    input  out_item_t res_item,
    output logic      res_full,
    input  logic      pop,
    output logic      empty,
    output out_item_t result
);

    out_item_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              wr_en;
    logic              rd_en;

    assign res_full = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign wr_en    = res_push && !res_full;
    assign rd_en    = pop && !empty;
    assign result   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= res_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= QPTR_W'((32'(wr_ptr_reg) + 1) % QUEUE_DEPTH);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= QPTR_W'((32'(rd_ptr_reg) + 1) % QUEUE_DEPTH);
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_out_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue count out of range");
    a_out_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("result queue pointers disagree while empty");
    a_out_noover: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");
`endif

endmodule

[hdl/scsc_exec.sv]
`timescale 1ns / 1ps
module scsc_exec
    import scsc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [WIN_W-1:0] cfg_data,
    input  front_t           front,
    output logic             take,
    output logic             res_push,
    output out_item_t        res_item,
    input  logic             res_full
);

    frame_t            mem [STACK_DEPTH];
    frame_t            rd_data_reg;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [IDX_W-1:0]  rd_idx;
    logic [CNT_W-1:0]  cnt_m1;

    exec_state_t       state_reg;
    exec_state_t       state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [WIN_W-1:0]  win_reg;
    in_item_t          item_reg;
    in_item_t          item_next;
    verdict_t          verdict_reg;
    verdict_t          verdict_next;
    logic [ADDR_W-1:0] shadow_reg;
    logic [ADDR_W-1:0] shadow_next;

    logic              stack_full;
    logic              stack_empty;
    logic              addr_hit;
    logic              sp_hit;

    assign cfg_ready   = 1'b1;
    assign cnt_m1      = count_reg - CNT_W'(1);
    assign rd_idx      = cnt_m1[IDX_W-1:0];
    assign wr_idx      = count_reg[IDX_W-1:0];
    assign stack_full  = (count_reg == CNT_W'(STACK_DEPTH));
    assign stack_empty = (count_reg == '0);
    assign addr_hit    = (rd_data_reg.link_addr == item_reg.code_address);
    assign sp_hit      = sp_near(item_reg.stack_pointer, rd_data_reg.sp, win_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= '{link_addr: front.item.code_address,
                              sp: front.item.stack_pointer};
        end
        rd_data_reg <= mem[rd_idx];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (front.avail)
                begin
                    if (front.item.command == CMD_RETURN && !stack_empty)
                    begin
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_CHECK:
            begin
                if (addr_hit || sp_hit || count_reg == CNT_W'(1))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_UNW_RD;
                end
            end
            ST_UNW_RD:
            begin
                state_next = ST_UNW_CK;
            end
            ST_UNW_CK:
            begin
                if ((addr_hit && sp_hit) || count_reg == CNT_W'(1))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_UNW_RD;
                end
            end
            ST_EMIT:
            begin
                if (!res_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        take         = 1'b0;
        wr_en        = 1'b0;
        res_push     = 1'b0;
        count_next   = count_reg;
        item_next    = item_reg;
        verdict_next = verdict_reg;
        shadow_next  = shadow_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (front.avail)
                begin
                    take      = 1'b1;
                    item_next = front.item;
                    if (front.item.command == CMD_CALL)
                    begin
                        if (stack_full)
                        begin
                            verdict_next = V_FULL;
                            shadow_next  = '0;
                        end
                        else
                        begin
                            wr_en        = 1'b1;
                            count_next   = count_reg + CNT_W'(1);
                            verdict_next = V_PUSHED;
                            shadow_next  = front.item.code_address;
                        end
                    end
                    else if (stack_empty)
                    begin
                        verdict_next = V_UNDERFLOW;
                        shadow_next  = '0;
                    end
                end
            end
            ST_CHECK:
            begin
                shadow_next = rd_data_reg.link_addr;
                if (addr_hit)
                begin
                    count_next   = cnt_m1;
                    verdict_next = sp_hit ? V_GOOD : V_GOOD_BAD_SP;
                end
                else if (sp_hit)
                begin
                    verdict_next = V_OVERWRITE;
                end
                else
                begin
                    count_next   = cnt_m1;
                    verdict_next = V_FWD_LONGJMP;
                end
            end
            ST_UNW_RD:
            begin
                count_next = count_reg;
            end
            ST_UNW_CK:
            begin
                count_next = cnt_m1;
                if (addr_hit && sp_hit)
                begin
                    verdict_next = V_BACK_LONGJMP;
                end
            end
            ST_EMIT:
            begin
                res_push = !res_full;
            end
            default:
            begin
                res_push = 1'b0;
            end
        endcase
    end

    assign res_item.verdict        = verdict_reg;
    assign res_item.depth_after    = DEPTH_W'(count_reg);
    assign res_item.shadow_address = shadow_reg;

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        verdict_reg <= verdict_next;
        shadow_reg  <= shadow_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            win_reg   <= WIN_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                win_reg <= cfg_data;
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("shadow stack count beyond depth");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (state_reg == ST_IDLE && front.avail))
        else $error("transaction taken while busy");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CNT_W'(1) ||
             count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("shadow stack count jumped");
    a_unwind_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UNW_RD || state_reg == ST_UNW_CK) |-> !stack_empty)
        else $error("unwind on an empty shadow stack");
`endif

endmodule

[hdl/shadow_call_stack_checker.sv]
`timescale 1ns / 1ps
// The executor takes one item at a time and takes no new item until the result of the last
// one is pushed to the result queue; emit waits while that queue is full. A call, an underflow
// or a full push goes from acceptance straight to the emit state; a return first goes to the
// check state, using the registered shadow memory read of the top entry, and an unwinding
// return then adds a read state and a check state per entry examined below the top.
// Reset clears both queues, the entry count and sets the window to 8; memory is not cleared.
module shadow_call_stack_checker
    import scsc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  in_item_t         item,
    output logic             empty,
    input  logic             pop,
    output out_item_t        result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [WIN_W-1:0] cfg_data
);

    front_t    front;
    logic      take;
    logic      res_push;
    logic      res_full;
    out_item_t res_item;

    scsc_in_q u_in_q
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .item  (item),
        .full  (full),
        .take  (take),
        .front (front)
    );

    scsc_exec u_exec
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .front     (front),
        .take      (take),
        .res_push  (res_push),
        .res_item  (res_item),
        .res_full  (res_full)
    );

    scsc_out_q u_out_q
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_item (res_item),
        .res_full (res_full),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

endmodule

[sim/tb_shadow_call_stack_checker.sv]
`timescale 1ns / 1ps
module tb_shadow_call_stack_checker;
    import scsc_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    in_item_t         item = '0;
    logic             empty;
    logic             pop = 1'b0;
    out_item_t        result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [WIN_W-1:0] cfg_data = '0;

    logic [ADDR_W-1:0] shadow_ret [STACK_DEPTH];
    logic [ADDR_W-1:0] shadow_sp [STACK_DEPTH];
    int                shadow_depth = 0;
    logic [WIN_W-1:0]  window_model = WIN_RESET;
    out_item_t         pending_verdicts[$];

    int   mismatches = 0;
    int   cycles = 0;
    int   burst_left = 0;
    bit   sender_gaps = 1'b1;
    logic hold_rx = 1'b0;
    int   rx_tick = 0;
    int   rx_mode = 0;

    shadow_call_stack_checker i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic frames_close(input logic [ADDR_W-1:0] a, b);
        logic [ADDR_W-1:0] gap;
        gap = (a >= b) ? (a - b) : (b - a);
        return gap <= {{(ADDR_W-WIN_W){1'b0}}, window_model};
    endfunction

    function automatic out_item_t judge_transfer(input cmd_t c,
                                                 input logic [ADDR_W-1:0] a, s);
        out_item_t r;
        int        top;
        logic      sp_ok;
        logic      found;
        r.verdict = V_PUSHED;
        r.shadow_address = '0;
        if (c == CMD_CALL)
        begin
            if (shadow_depth >= STACK_DEPTH)
                r.verdict = V_FULL;
            else
            begin
                shadow_ret[shadow_depth] = a;
                shadow_sp[shadow_depth] = s;
                shadow_depth++;
                r.shadow_address = a;
            end
        end
        else if (shadow_depth == 0)
            r.verdict = V_UNDERFLOW;
        else
        begin
            top = shadow_depth - 1;
            sp_ok = frames_close(s, shadow_sp[top]);
            r.shadow_address = shadow_ret[top];
            if (shadow_ret[top] == a)
            begin
                shadow_depth = top;
                r.verdict = sp_ok ? V_GOOD : V_GOOD_BAD_SP;
            end
            else if (sp_ok)
                r.verdict = V_OVERWRITE;
            else
            begin
                found = 1'b0;
                while (shadow_depth > 0 && !found)
                begin
                    shadow_depth--;
                    if (shadow_ret[shadow_depth] == a &&
                        frames_close(s, shadow_sp[shadow_depth]))
                        found = 1'b1;
                end
                r.verdict = found ? V_BACK_LONGJMP : V_FWD_LONGJMP;
            end
        end
        r.depth_after = DEPTH_W'(shadow_depth);
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ADDR_W-1:0] sp_near(input logic [ADDR_W-1:0] base);
        logic [ADDR_W-1:0] off;
        off = $urandom_range(0, window_model);
        return $urandom_range(0, 1) ? base + off : base - off;
    endfunction

    function automatic logic [ADDR_W-1:0] sp_far(input logic [ADDR_W-1:0] base);
        logic [ADDR_W-1:0] off;
        off = window_model + 1 + $urandom_range(0, 4096);
        return $urandom_range(0, 1) ? base + off : base - off;
    endfunction

    task automatic send_item(input cmd_t c, input logic [ADDR_W-1:0] a, s);
        in_item_t t;
        int       gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = sender_gaps ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        t.command = c;
        t.code_address = a;
        t.stack_pointer = s;
        push <= 1'b1;
        item <= t;
        do
            @(posedge clk);
        while (full);
        pending_verdicts.push_back(judge_transfer(c, a, s));
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        burst_left = 0;
        while (pending_verdicts.size() > 0)
            @(posedge clk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] w);
        cfg_valid <= 1'b1;
        cfg_data <= w;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        window_model = w;
    endtask

    task automatic send_random();
        cmd_t              c;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] s;
        int                roll;
        int                kind;
        int                call_pct;
        int                top;
        int                j;
        roll = $urandom_range(0, 99);
        call_pct = (shadow_depth == 0) ? 85 : (shadow_depth > 40) ? 25 : 52;
        top = shadow_depth - 1;
        if (roll < call_pct)
        begin
            c = CMD_CALL;
            a = rand64();
            if (shadow_depth == 0 || $urandom_range(0, 9) == 0)
                s = rand64();
            else
                s = shadow_sp[top] - $urandom_range(16, 512);
        end
        else
        begin
            c = CMD_RETURN;
            kind = $urandom_range(0, 99);
            if (shadow_depth == 0 || kind >= 92)
            begin
                a = rand64();
                s = rand64();
            end
            else if (kind < 50)
            begin
                a = shadow_ret[top];
                s = ($urandom_range(0, 4) == 0) ? sp_far(shadow_sp[top])
                                                : sp_near(shadow_sp[top]);
            end
            else if (kind < 62)
            begin
                a = shadow_ret[top] ^ (rand64() | 64'd1);
                s = sp_near(shadow_sp[top]);
            end
            else if (kind < 82)
            begin
                j = $urandom_range(0, top);
                a = shadow_ret[j];
                s = sp_near(shadow_sp[j]);
            end
            else
            begin
                a = rand64();
                s = sp_far(shadow_sp[top]);
            end
        end
        send_item(c, a, s);
    endtask

    task automatic report_mismatch(input string field, input logic [ADDR_W-1:0] want, got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s differs: expected %0h, got %0h", $realtime, field, want, got);
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_verdicts.size() == 0)
                report_mismatch("unexpected transaction", '0, result.shadow_address);
            else
            begin
                want = pending_verdicts.pop_front();
                if (result.verdict !== want.verdict)
                    report_mismatch("verdict", want.verdict, result.verdict);
                if (result.depth_after !== want.depth_after)
                    report_mismatch("depth_after", want.depth_after, result.depth_after);
                if (result.shadow_address !== want.shadow_address)
                    report_mismatch("shadow_address", want.shadow_address,
                                    result.shadow_address);
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            rx_tick = rx_tick + 1;
            if (rx_tick % 80 == 0)
                rx_mode = $urandom_range(0, 3);
            if (hold_rx)
                pop <= 1'b0;
            else
                case (rx_mode)
                    0: pop <= 1'b1;
                    1: pop <= $urandom_range(0, 1);
                    2: pop <= ($urandom_range(0, 3) == 0);
                    default: pop <= (rx_tick % 3 != 0);
                endcase
        end
    end

    task automatic test_directed();
        send_item(CMD_RETURN, '1, '1);
        send_item(CMD_CALL, '0, '0);
        send_item(CMD_CALL, '1, '1);
        send_item(CMD_RETURN, '1, 64'hFFFF_FFFF_FFFF_FFF7);
        send_item(CMD_CALL, 64'h0000_0000_0040_1000, 64'h1000);
        send_item(CMD_RETURN, 64'h0000_0000_0040_1000, 64'h1009);
        send_item(CMD_CALL, 64'h0000_0000_0040_2000, 64'h2000);
        send_item(CMD_RETURN, 64'hDEAD_BEEF_0000_0001, 64'h2008);
        send_item(CMD_RETURN, 64'h0000_0000_0040_2000, 64'h2000);
        send_item(CMD_CALL, 64'hA5A5_0000_0000_3000, 64'h3000);
        send_item(CMD_CALL, 64'h5A5A_0000_0000_2F00, 64'h2F00);
        send_item(CMD_CALL, 64'hA5A5_0000_0000_2E00, 64'h2E00);
        send_item(CMD_RETURN, 64'hA5A5_0000_0000_3000, 64'h3004);
        send_item(CMD_RETURN, '0, '1);
        send_item(CMD_CALL, 64'h8000_0000_0000_4000, 64'h4000);
        send_item(CMD_CALL, 64'h8000_0000_0000_4100, 64'h4100);
        send_item(CMD_RETURN, 64'h7FFF_FFFF_FFFF_FFFF, 64'h9000);
        send_item(CMD_CALL, 64'h1234_5678_9ABC_DEF0, '0);
        send_item(CMD_RETURN, 64'h0FED_CBA9_8765_4321, '1);
        wait_drained();
    endtask

    task automatic test_full_stack();
        int n;
        for (n = 0; n < STACK_DEPTH; n++)
            send_item(CMD_CALL, rand64(), 64'h7FFF_0000 - 64'(n * 32));
        send_item(CMD_CALL, rand64(), rand64());
        send_item(CMD_CALL, '1, '0);
        send_item(CMD_RETURN, rand64(), '0);
        send_item(CMD_RETURN, rand64(), rand64());
        wait_drained();
    endtask

    task automatic test_backpressure();
        int n;
        sender_gaps = 1'b0;
        fork
            begin
                hold_rx <= 1'b1;
                repeat (300) @(posedge clk);
                hold_rx <= 1'b0;
            end
        join_none
        for (n = 0; n < 60; n++)
            send_random();
        wait_drained();
        sender_gaps = 1'b1;
    endtask

    task automatic test_windows();
        logic [WIN_W-1:0] settings [4];
        int               k;
        int               n;
        settings = '{8'd0, 8'd255, 8'd1, 8'd128};
        for (k = 0; k < 4; k++)
        begin
            write_window(settings[k]);
            for (n = 0; n < 50; n++)
                send_random();
            wait_drained();
        end
    endtask

    task automatic test_random();
        int phase;
        int n;
        for (phase = 0; phase < 6; phase++)
        begin
            write_window(phase == 5 ? WIN_RESET : WIN_W'($urandom_range(0, 255)));
            sender_gaps = phase % 2 == 0;
            for (n = 0; n < 60; n++)
                send_random();
            wait_drained();
        end
        sender_gaps = 1'b1;
    endtask

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("shadow_call_stack_checker: mismatch");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_stack();
        test_backpressure();
        test_windows();
        test_random();
        repeat (600) @(posedge clk);
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("shadow_call_stack_checker: match");
        else
            $display("shadow_call_stack_checker: mismatch");
        $finish;
    end

endmodule
